// File: sv/pdt_pkg.sv
// pdt_pkg: shared types and constants for the pump dose timer with dry-run guard
// no dependencies; used by pump_dose_timer_dry_run_guard

package pdt_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int VOL_W     = 8;
    localparam int SAMPLE_W  = 10;
    localparam int DUR_W     = 16;
    localparam int WARM_W    = 16;
    localparam int THR_W     = 10;
    localparam int EVENT_W   = 2;
    localparam int AVG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // elapsed counter, saturating
    localparam int                ELAPSED_W   = 24;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // moving average window
    localparam int WINDOW   = 10;
    localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W    = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

    // division of the window sum by WINDOW as multiply by reciprocal and shift
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W   = SUM_W + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int PROD_W    = SUM_W + RECIP_W;

    // reset values of the configuration registers
    localparam logic [DUR_W-1:0]  UNIT_DUR_RESET  = DUR_W'(7000);
    localparam logic [WARM_W-1:0] WARMUP_RESET    = '0;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(530);

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_TOGGLE = 2'd3
    } t_op;

    // result events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_DONE  = 2'd1,
        EV_EMPTY = 2'd2
    } t_event;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_DURATION = 2'd0,
        CFG_WARMUP        = 2'd1,
        CFG_THRESHOLD     = 2'd2
    } t_cfg_idx;

endpackage

// File: sv/pump_dose_timer_dry_run_guard.sv
// pump_dose_timer_dry_run_guard: timed pump dose control with moving-average dry-run stop
// depends on pdt_pkg (types, widths, window and reciprocal constants)
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_op, i_volume_units, i_sample
// result    out        o_out_valid / i_out_ready  o_pump_on, o_event_res, o_average
// config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One item per cycle while results are taken: all state is updated in the cycle the
// item is taken and the result lands in a single output register, shown the next cycle.
// The 16x8 dose-time product is compared against the elapsed count.
// The input is taken while the output register is empty or being drained, so a
// stalled result blocks the input only for as long as it is not taken.
// Synchronous active-low reset clears control state; the sample ring is not cleared,
// since entries not yet written in a pour are masked by the fill flag.

module pump_dose_timer_dry_run_guard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pdt_pkg::OP_W-1:0]       i_op,
    input  logic [pdt_pkg::VOL_W-1:0]      i_volume_units,
    input  logic [pdt_pkg::SAMPLE_W-1:0]   i_sample,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_pump_on,
    output logic [pdt_pkg::EVENT_W-1:0]    o_event_res,
    output logic [pdt_pkg::AVG_W-1:0]      o_average,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdt_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [pdt_pkg::DUR_W-1:0]  r_unit_dur;
    logic [pdt_pkg::WARM_W-1:0] r_warmup;
    logic [pdt_pkg::THR_W-1:0]  r_threshold;

    // control state
    logic                           r_pouring,  n_pouring;
    logic [pdt_pkg::ELAPSED_W-1:0]  r_elapsed,  n_elapsed;
    logic [pdt_pkg::VOL_W-1:0]      r_dose,     n_dose;
    logic [pdt_pkg::POS_W-1:0]      r_pos,      n_pos;
    logic [pdt_pkg::SUM_W-1:0]      r_sum,      n_sum;
    logic                           r_full,     n_full;

    // sample ring
    logic [pdt_pkg::SAMPLE_W-1:0]   r_win [pdt_pkg::WINDOW];
    logic                           win_we;

    // output register
    logic                           r_out_valid;
    logic                           r_out_pump;
    pdt_pkg::t_event                r_out_event;
    logic [pdt_pkg::SUM_W-1:0]      r_out_sum;

    // per-item datapath
    logic                           accept;
    pdt_pkg::t_op                   op;
    pdt_pkg::t_event                n_event;
    logic [pdt_pkg::ELAPSED_W-1:0]  elapsed_inc;
    logic [pdt_pkg::ELAPSED_W-1:0]  target;
    logic [pdt_pkg::SAMPLE_W-1:0]   evict;
    logic [pdt_pkg::SUM_W-1:0]      sum_push;
    logic [pdt_pkg::SUM_W-1:0]      thr_scaled;
    logic                           pos_wrap;
    logic                           full_push;
    logic [pdt_pkg::PROD_W-1:0]     avg_prod;

    // handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign op         = pdt_pkg::t_op'(i_op);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_dur  <= pdt_pkg::UNIT_DUR_RESET;
            r_warmup    <= pdt_pkg::WARMUP_RESET;
            r_threshold <= pdt_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (pdt_pkg::t_cfg_idx'(i_cfg_idx))
                pdt_pkg::CFG_UNIT_DURATION: r_unit_dur  <= i_cfg_data[pdt_pkg::DUR_W-1:0];
                pdt_pkg::CFG_WARMUP:        r_warmup    <= i_cfg_data[pdt_pkg::WARM_W-1:0];
                pdt_pkg::CFG_THRESHOLD:     r_threshold <= i_cfg_data[pdt_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // shared terms: saturating count, dose time, window push
    always_comb begin
        elapsed_inc = (r_elapsed == pdt_pkg::ELAPSED_MAX) ? r_elapsed
                                                          : r_elapsed + 1'b1;
        target      = pdt_pkg::ELAPSED_W'(r_unit_dur) * pdt_pkg::ELAPSED_W'(r_dose);
        evict       = r_full ? r_win[r_pos] : '0;
        sum_push    = r_sum - pdt_pkg::SUM_W'(evict) + pdt_pkg::SUM_W'(i_sample);
        pos_wrap    = (r_pos == pdt_pkg::POS_W'(pdt_pkg::WINDOW - 1));
        full_push   = r_full || pos_wrap;
        // floor(sum / WINDOW) < thr  is the same as  sum < thr * WINDOW
        thr_scaled  = pdt_pkg::SUM_W'(r_threshold) * pdt_pkg::SUM_W'(pdt_pkg::WINDOW);
    end

    // next state and event for the item
    always_comb begin
        n_pouring = r_pouring;
        n_elapsed = r_elapsed;
        n_dose    = r_dose;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_full    = r_full;
        n_event   = pdt_pkg::EV_NONE;
        win_we    = 1'b0;
        if (accept) begin
            case (op)
                pdt_pkg::OP_TICK: begin
                    n_elapsed = elapsed_inc;
                    if (r_pouring) begin
                        if (elapsed_inc >= target) begin
                            // dose time reached
                            n_pouring = 1'b0;
                            n_elapsed = '0;
                            n_event   = pdt_pkg::EV_DONE;
                        end else begin
                            // sample enters the window
                            win_we = 1'b1;
                            n_sum  = sum_push;
                            n_pos  = pos_wrap ? '0 : r_pos + 1'b1;
                            n_full = full_push;
                            if (sum_push < thr_scaled && full_push &&
                                elapsed_inc >= pdt_pkg::ELAPSED_W'(r_warmup)) begin
                                n_pouring = 1'b0;
                                n_elapsed = '0;
                                n_event   = pdt_pkg::EV_EMPTY;
                            end
                        end
                    end
                end
                pdt_pkg::OP_START: begin
                    n_pouring = 1'b1;
                    n_elapsed = '0;
                    n_dose    = i_volume_units;
                    n_pos     = '0;
                    n_sum     = '0;
                    n_full    = 1'b0;
                end
                pdt_pkg::OP_STOP: begin
                    n_pouring = 1'b0;
                    n_elapsed = '0;
                end
                pdt_pkg::OP_TOGGLE: begin
                    n_elapsed = '0;
                    if (r_pouring) begin
                        n_pouring = 1'b0;
                    end else begin
                        // start of one unit
                        n_pouring = 1'b1;
                        n_dose    = pdt_pkg::VOL_W'(1);
                        n_pos     = '0;
                        n_sum     = '0;
                        n_full    = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pouring <= 1'b0;
            r_elapsed <= '0;
            r_dose    <= '0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_full    <= 1'b0;
        end else begin
            r_pouring <= n_pouring;
            r_elapsed <= n_elapsed;
            r_dose    <= n_dose;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_full    <= n_full;
        end
    end

    // sample ring write
    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win[r_pos] <= i_sample;
        end
    end

    // output register with valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_pump  <= n_pouring;
            r_out_event <= n_event;
            r_out_sum   <= n_sum;
        end
    end

    // average: sum times reciprocal of the window depth
    assign avg_prod    = pdt_pkg::PROD_W'(r_out_sum) * pdt_pkg::PROD_W'(pdt_pkg::RECIP);
    assign o_average   = pdt_pkg::AVG_W'(avg_prod >> pdt_pkg::DIV_SHIFT);
    assign o_out_valid = r_out_valid;
    assign o_pump_on   = r_out_pump;
    assign o_event_res = r_out_event;

endmodule
